// File: rtl/bsa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap slot allocator package
// Request and response types, command and status codes, and the small
// helpers shared by the allocator modules.
// ----------------------------------------------------------------------------
package bsa_pkg;

  // Default number of 8-slot buckets that are built.
  localparam int BucketsDefault = 64;
  localparam int SlotsPerBucket = 8;
  localparam int MaskW          = SlotsPerBucket;
  localparam int BitW           = 3;
  localparam int SlotW          = 9;
  localparam int CountW         = 10;
  localparam int ActiveW        = 7;
  localparam logic [MaskW-1:0] MaskFull = 8'hFF;

  typedef enum logic [1:0] {
    CmdAlloc = 2'd0,
    CmdFree  = 2'd1,
    CmdCheck = 2'd2,
    CmdNop   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    StatusOk      = 2'd0,
    StatusFull    = 2'd1,
    StatusBadFree = 2'd2
  } status_e;

  typedef struct packed {
    cmd_e             cmd;
    logic [SlotW-1:0] slot_index;
  } req_t;

  typedef struct packed {
    status_e           status;
    logic [SlotW-1:0]  granted_slot;
    logic              occupied;
    logic [CountW-1:0] used_count;
  } rsp_t;

  // Position of the lowest clear bit of an occupancy mask. A full mask
  // yields zero; callers only use the result when the mask has room.
  function automatic logic [BitW-1:0] lowest_zero_bit(logic [MaskW-1:0] mask);
    logic [BitW-1:0] pos;
    pos = '0;
    for (int b = MaskW - 1; b >= 0; b--) begin
      if (!mask[b]) begin
        pos = BitW'(b);
      end
    end
    return pos;
  endfunction

endpackage

// File: rtl/bsa_mask_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Occupancy mask memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module bsa_mask_ram #(
  parameter int Buckets = bsa_pkg::BucketsDefault,
  parameter int AddrW   = (Buckets > 1) ? $clog2(Buckets) : 1
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [AddrW-1:0]         waddr_i,
  input  logic [bsa_pkg::MaskW-1:0] wdata_i,
  input  logic                     re_i,
  input  logic [AddrW-1:0]         raddr_i,
  output logic [bsa_pkg::MaskW-1:0] rdata_o
);

  logic [bsa_pkg::MaskW-1:0] mem_q [Buckets];
  logic [bsa_pkg::MaskW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/bsa_bucket_finder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Free bucket finder
// Priority encoder over the bucket-full flags, starting at the search hint
// and bounded by the active bucket count.
// ----------------------------------------------------------------------------
module bsa_bucket_finder #(
  parameter int Buckets = bsa_pkg::BucketsDefault,
  parameter int AddrW   = (Buckets > 1) ? $clog2(Buckets) : 1
) (
  input  logic [Buckets-1:0]          full_i,
  input  logic [AddrW-1:0]            hint_i,
  input  logic [bsa_pkg::ActiveW-1:0] active_i,
  output logic                        found_o,
  output logic [AddrW-1:0]            bucket_o
);

  logic [Buckets-1:0] cand;

  always_comb begin
    for (int i = 0; i < Buckets; i++) begin
      cand[i] = !full_i[i] && (i >= int'(hint_i)) && (i < int'(active_i));
    end
  end

  always_comb begin
    found_o  = 1'b0;
    bucket_o = '0;
    for (int i = Buckets - 1; i >= 0; i--) begin
      if (cand[i]) begin
        found_o  = 1'b1;
        bucket_o = AddrW'(i);
      end
    end
  end

endmodule

// File: rtl/bitmap_slot_allocator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap slot allocator
// Fixed-slot allocator over 8-slot buckets with a search hint and a used
// slot count. Serves allocate, free and check requests.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake                 Payload
//   -------   ---------  ------------------------  -----------------------
//   request   in         req_valid_i / req_stall_o  req_i  (bsa_pkg::req_t)
//   response  out        rsp_valid_o / rsp_stall_i  rsp_o  (bsa_pkg::rsp_t)
//   config    in         cfg_we_i (no wait)         cfg_wdata_i (active buckets)
//
// A request is taken in the idle state, where its target bucket is chosen
// (by the free-bucket priority encoder for an allocate, from the slot index
// otherwise) and its mask is read; in the exec state the mask is modified
// and written back and the response is loaded. The single read-modify-write
// of the mask memory means no new request is taken before that write-back.
// Reset clears the per-bucket valid flags at once, so no clearing pass is
// needed. While a response is stalled one more request can be taken and
// read, but its write-back waits and no further request is taken.
//
module bitmap_slot_allocator_unit #(
  parameter int BUCKETS = bsa_pkg::BucketsDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [bsa_pkg::ActiveW-1:0] cfg_wdata_i,
  input  logic                        req_valid_i,
  output logic                        req_stall_o,
  input  bsa_pkg::req_t               req_i,
  output logic                        rsp_valid_o,
  input  logic                        rsp_stall_i,
  output bsa_pkg::rsp_t               rsp_o
);

  localparam int BktW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam logic [bsa_pkg::ActiveW-1:0] ActiveReset =
    (BUCKETS > 127) ? bsa_pkg::ActiveW'(127) : bsa_pkg::ActiveW'(BUCKETS);

  // Sequencer states.
  localparam logic StIdle = 1'b0;
  localparam logic StExec = 1'b1;

  logic state_q, state_d;

  // Configuration and architectural state kept in flip-flops.
  logic [bsa_pkg::ActiveW-1:0] active_q;
  logic [BktW-1:0]             hint_q, hint_d;
  logic [bsa_pkg::CountW-1:0]  count_q, count_d;
  // A bucket is full when all eight slots are taken; a bucket that was
  // never written reads as empty through its valid flag.
  logic [BUCKETS-1:0]          full_q;
  logic [BUCKETS-1:0]          valid_q;

  // The request being worked on.
  bsa_pkg::cmd_e               cmd_q;
  logic [bsa_pkg::BitW-1:0]    bit_q;
  logic [BktW-1:0]             bkt_q;
  logic                        hit_q;

  // Output register.
  bsa_pkg::rsp_t               rsp_q, rsp_d;
  logic                        rsp_valid_q;

  logic                        req_acc;
  logic                        exec_go;
  logic                        find_found;
  logic [BktW-1:0]             find_bkt;
  logic [5:0]                  slot_bkt;
  logic                        slot_in_range;
  logic [BktW-1:0]             lookup_bkt;
  logic                        lookup_hit;

  logic [bsa_pkg::MaskW-1:0]   ram_rdata;
  logic [bsa_pkg::MaskW-1:0]   cur_mask;
  logic [bsa_pkg::MaskW-1:0]   new_mask;
  logic                        mem_we;
  logic [bsa_pkg::BitW-1:0]    free_bit;

  assign req_stall_o = (state_q != StIdle);
  assign req_acc     = req_valid_i && !req_stall_o;
  // The write-back and the response load happen together, so they wait
  // until the output register can take the response.
  assign exec_go     = (state_q == StExec) && !(rsp_valid_q && rsp_stall_i);

  // An allocate looks for the first bucket with room from the hint upward.
  bsa_bucket_finder #(
    .Buckets (BUCKETS)
  ) u_finder (
    .full_i   (full_q),
    .hint_i   (hint_q),
    .active_i (active_q),
    .found_o  (find_found),
    .bucket_o (find_bkt)
  );

  // A free or check names its bucket directly; it must lie below both the
  // active count and the built depth.
  assign slot_bkt      = req_i.slot_index[bsa_pkg::SlotW-1:bsa_pkg::BitW];
  assign slot_in_range = ({1'b0, slot_bkt} < active_q) && (int'(slot_bkt) < BUCKETS);

  always_comb begin
    if (req_i.cmd == bsa_pkg::CmdAlloc) begin
      lookup_bkt = find_bkt;
      lookup_hit = find_found;
    end else begin
      lookup_bkt = BktW'(slot_bkt);
      lookup_hit = slot_in_range;
    end
  end

  bsa_mask_ram #(
    .Buckets (BUCKETS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (bkt_q),
    .wdata_i (new_mask),
    .re_i    (req_acc),
    .raddr_i (lookup_bkt),
    .rdata_o (ram_rdata)
  );

  assign cur_mask = valid_q[bkt_q] ? ram_rdata : '0;
  assign free_bit = bsa_pkg::lowest_zero_bit(cur_mask);

  // Modify step: decide the new mask, the hint, the count and the response.
  always_comb begin
    mem_we   = 1'b0;
    new_mask = cur_mask;
    hint_d   = hint_q;
    count_d  = count_q;
    rsp_d    = '{status:       bsa_pkg::StatusOk,
                 granted_slot: '0,
                 occupied:     1'b0,
                 used_count:   count_q};
    unique case (cmd_q)
      bsa_pkg::CmdAlloc: begin
        if (hit_q) begin
          mem_we             = exec_go;
          new_mask           = cur_mask | (bsa_pkg::MaskW'(1) << free_bit);
          hint_d             = bkt_q;
          count_d            = count_q + bsa_pkg::CountW'(1);
          rsp_d.granted_slot = bsa_pkg::SlotW'({bkt_q, free_bit});
        end else begin
          rsp_d.status = bsa_pkg::StatusFull;
        end
      end
      bsa_pkg::CmdFree: begin
        if (hit_q && cur_mask[bit_q]) begin
          mem_we   = exec_go;
          new_mask = cur_mask & ~(bsa_pkg::MaskW'(1) << bit_q);
          if (hint_q > bkt_q) begin
            hint_d = bkt_q;
          end
          count_d  = count_q - bsa_pkg::CountW'(1);
        end else begin
          rsp_d.status = bsa_pkg::StatusBadFree;
        end
      end
      bsa_pkg::CmdCheck: begin
        rsp_d.occupied = hit_q && cur_mask[bit_q];
      end
      default: begin
      end
    endcase
    rsp_d.used_count = count_d;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (req_acc) begin
          state_d = StExec;
        end
      end
      StExec: begin
        if (exec_go) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      active_q    <= ActiveReset;
      hint_q      <= '0;
      count_q     <= '0;
      full_q      <= '0;
      valid_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        active_q <= cfg_wdata_i;
      end
      if (exec_go) begin
        hint_q      <= hint_d;
        count_q     <= count_d;
        rsp_valid_q <= 1'b1;
      end else if (!rsp_stall_i) begin
        rsp_valid_q <= 1'b0;
      end
      if (mem_we) begin
        full_q[bkt_q]  <= (new_mask == bsa_pkg::MaskFull);
        valid_q[bkt_q] <= 1'b1;
      end
    end
  end

  // Request fields and response payload need no reset.
  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      cmd_q <= req_i.cmd;
      bit_q <= req_i.slot_index[bsa_pkg::BitW-1:0];
      bkt_q <= lookup_bkt;
      hit_q <= lookup_hit;
    end
    if (exec_go) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule
